// ===== rtl/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_pkg
// Types and constants shared by the point matrix transform and its checker.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int FRAC_BITS = 16;              // Q format fraction bits, 8..24
  localparam int MAT_ENTRIES = 16;
  localparam int H_W   = 66;                   // column sum width, signed
  localparam int MAG_W = 64;                   // |h| always below 2^64
  localparam int NUM_W = MAG_W + FRAC_BITS;    // scaled numerator
  localparam int QUO_W = 33;                   // quotient bits kept after overflow test
  localparam int DIV_W = MAG_W + QUO_W;        // widest shifted divisor
  localparam int LATENCY = 39;                 // accept sample to done sample, in edges

  localparam logic MODE_LOAD      = 1'b0;
  localparam logic MODE_TRANSFORM = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [3:0]        entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               divide_error;
  } result_t;

endpackage

// ===== rtl/point_matrix_transform.sv =====
// ----------------------------------------------------------------------------
// point_matrix_transform
// 4x4 homogeneous point transform with perspective divide, Q16.16.
// ----------------------------------------------------------------------------
// A new item is taken every cycle (busy is never raised). Load items write
// one matrix entry and give no result; a transform item gives its result,
// marked by done, after it has passed the product, column sum, numerator
// and divider stages. The three parallel restoring dividers resolve one
// quotient bit per pipeline stage after a stage that tests for saturation.
// A load takes effect for every transform taken after it.
module point_matrix_transform
  import pmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic signed [31:0] matrix [MAT_ENTRIES];

  logic               a_valid;
  logic signed [31:0] a_p [3];

  logic               b_valid;
  logic signed [63:0] b_prod [3][4];
  logic signed [31:0] b_w [4];

  logic                  c_valid;
  logic signed [H_W-1:0] c_h [4];

  logic               d_valid;
  logic [NUM_W-1:0]   d_num [3];
  logic               d_neg [3];
  logic [MAG_W-1:0]   d_den;
  logic               d_err;

  logic               s_valid [QUO_W+1];
  logic [NUM_W-1:0]   s_rem [QUO_W+1][3];
  logic [QUO_W-1:0]   s_quo [QUO_W+1][3];
  logic               s_ovf [QUO_W+1][3];
  logic               s_neg [QUO_W+1][3];
  logic [MAG_W-1:0]   s_den [QUO_W+1];
  logic               s_err [QUO_W+1];

  logic [NUM_W-1:0]   s_rem_next [QUO_W+1][3];
  logic [QUO_W-1:0]   s_quo_next [QUO_W+1][3];
  logic               s_ovf_next [QUO_W+1][3];

  logic [MAG_W-1:0]   mag_next [4];
  logic signed [31:0] q_out [3];

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // matrix store
  always_ff @(posedge clk) begin
    if (accept && item.mode == MODE_LOAD) begin
      matrix[item.entry_index] <= item.entry_value;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      for (int j = 0; j <= QUO_W; j++) s_valid[j] <= 1'b0;
      done <= 1'b0;
    end else begin
      a_valid    <= accept && item.mode == MODE_TRANSFORM;
      b_valid    <= a_valid;
      c_valid    <= b_valid;
      d_valid    <= c_valid;
      s_valid[0] <= d_valid;
      for (int j = 1; j <= QUO_W; j++) s_valid[j] <= s_valid[j-1];
      done <= s_valid[QUO_W];
    end
  end

  // sign magnitude of the column sums
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag_next[c] = c_h[c][H_W-1] ? MAG_W'(-c_h[c]) : MAG_W'(c_h[c]);
    end
  end

  // divider steps: stage 0 tests for overflow, stage j resolves bit QUO_W-j
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      s_rem_next[0][l] = d_num[l];
      s_quo_next[0][l] = '0;
      s_ovf_next[0][l] = DIV_W'(d_num[l]) >= (DIV_W'(d_den) << QUO_W);
    end
    for (int j = 1; j <= QUO_W; j++) begin
      for (int l = 0; l < 3; l++) begin
        logic [DIV_W-1:0] sh;
        logic             ge;
        sh = DIV_W'(s_den[j-1]) << (QUO_W - j);
        ge = DIV_W'(s_rem[j-1][l]) >= sh;
        s_rem_next[j][l] = ge ? NUM_W'(DIV_W'(s_rem[j-1][l]) - sh) : s_rem[j-1][l];
        s_quo_next[j][l] = {s_quo[j-1][l][QUO_W-2:0], ge};
        s_ovf_next[j][l] = s_ovf[j-1][l];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    a_p[0] <= item.point_x;
    a_p[1] <= item.point_y;
    a_p[2] <= item.point_z;

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        b_prod[r][c] <= 64'(a_p[r]) * 64'(matrix[r*4+c]);
      end
    end
    for (int c = 0; c < 4; c++) b_w[c] <= matrix[12+c];

    for (int c = 0; c < 4; c++) begin
      c_h[c] <= H_W'(b_prod[0][c]) + H_W'(b_prod[1][c]) + H_W'(b_prod[2][c])
              + (H_W'(b_w[c]) <<< FRAC_BITS);
    end

    d_den <= mag_next[3];
    d_err <= c_h[3] == '0;
    for (int l = 0; l < 3; l++) begin
      d_num[l] <= NUM_W'(mag_next[l]) << FRAC_BITS;
      d_neg[l] <= c_h[l][H_W-1] ^ c_h[3][H_W-1];
    end

    for (int j = 0; j <= QUO_W; j++) begin
      s_den[j] <= (j == 0) ? d_den : s_den[j-1];
      s_err[j] <= (j == 0) ? d_err : s_err[j-1];
      for (int l = 0; l < 3; l++) begin
        s_rem[j][l] <= s_rem_next[j][l];
        s_quo[j][l] <= s_quo_next[j][l];
        s_ovf[j][l] <= s_ovf_next[j][l];
        s_neg[j][l] <= (j == 0) ? d_neg[l] : s_neg[j-1][l];
      end
    end

    result.out_x        <= q_out[0];
    result.out_y        <= q_out[1];
    result.out_z        <= q_out[2];
    result.divide_error <= s_err[QUO_W];
  end

  // sign, saturation and zero-w masking
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [QUO_W-1:0] q;
      q = s_quo[QUO_W][l];
      if (s_err[QUO_W]) begin
        q_out[l] = '0;
      end else if (s_neg[QUO_W][l]) begin
        if (s_ovf[QUO_W][l] || q > QUO_W'(33'h080000000)) q_out[l] = 32'sh80000000;
        else q_out[l] = 32'(QUO_W'(0) - q);
      end else begin
        if (s_ovf[QUO_W][l] || q[QUO_W-1] || q[31]) q_out[l] = 32'sh7FFFFFFF;
        else q_out[l] = q[31:0];
      end
    end
  end

endmodule

// ===== rtl/pmt_checker.sv =====
// ----------------------------------------------------------------------------
// pmt_checker
// Port-level checks for the point matrix transform, bound to the top level.
// ----------------------------------------------------------------------------
module pmt_checker
  import pmt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  logic [5:0] settle;
  logic       settled;

  // pipeline history is only meaningful once it has refilled after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else if (!settled) begin
      settle <= settle + 6'd1;
    end
  end
  assign settled = settle == 6'(LATENCY);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    settled |-> (done == $past(start && !busy && item.mode == MODE_TRANSFORM, LATENCY)))
    else $error("result does not match a transform item taken earlier");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.divide_error) |->
      (result.out_x == 0 && result.out_y == 0 && result.out_z == 0))
    else $error("zero w with non-zero outputs");

endmodule

bind point_matrix_transform pmt_checker u_pmt_checker (.*);
